[design/bx3_pkg.sv]
// bx3_pkg: shared widths, constants and configuration register codes for the
// 3x3 window sum extrema search block.
// No dependencies.
package bx3_pkg;

    localparam int WIN        = 3;
    localparam int ROW_LIMIT  = 32;
    localparam int DIM_W      = 6;
    localparam int POS_W      = 5;
    localparam int OUT_SUM_W  = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;

    typedef logic [DIM_W-1:0] dim_t;
    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } cfg_reg_t;

endpackage

[design/box3x3_sum_extrema_search.sv]
// box3x3_sum_extrema_search: 3x3 window sum max/min search over a streamed matrix.
// Depends on bx3_pkg.
//
// Usage:
//   Elements enter row-major on the input channel (in_valid/in_stall, payload
//   element_value). A transaction is accepted on a rising edge with valid high
//   and stall low. After the last element of a num_rows x num_cols matrix one
//   result transaction (max/min window sum and top-left corners) is offered on
//   the output channel (out_valid/out_stall).
//   Throughput: one element per cycle while in_stall is low. After the last
//   element is accepted the result passes the memory read, sum and compare stages.
//   The line memory holds the two rows above the current one, one entry per
//   column, with one read and one write per cycle; a column is read on
//   acceptance, written back from stage 1 and not read again for three transactions.
//   A stalled result holds in the output register while input continues; input
//   stalls only if a second result reaches the last stage before the first one
//   is taken.
//   Reset clears counters, bests and out_valid; the line memory is not cleared,
//   as the first two rows of every matrix rewrite it before it is used.
//   A write to num_rows or num_cols restarts the matrix (write only when idle).
module box3x3_sum_extrema_search #(
    parameter int MAX_COLS     = 32,
    parameter int ELEMENT_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bx3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bx3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ELEMENT_BITS-1:0]        element_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bx3_pkg::OUT_SUM_W-1:0]  max_sum,
    output logic [bx3_pkg::POS_W-1:0]      max_row,
    output logic [bx3_pkg::POS_W-1:0]      max_col,
    output logic [bx3_pkg::OUT_SUM_W-1:0]  min_sum,
    output logic [bx3_pkg::POS_W-1:0]      min_row,
    output logic [bx3_pkg::POS_W-1:0]      min_col
);
    import bx3_pkg::*;

    localparam int CIDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int COL_TOP = (MAX_COLS < 32) ? MAX_COLS : 32;
    localparam int CS_W    = ELEMENT_BITS + 2;
    localparam int SUM_W   = ELEMENT_BITS + 4;

    function automatic dim_t clamp_dim(input dim_t v, input dim_t top);
        dim_t res;
        if (v < dim_t'(WIN))
            res = dim_t'(WIN);
        else if (v > top)
            res = top;
        else
            res = v;
        return res;
    endfunction

    // configuration
    dim_t num_rows_reg;
    dim_t num_cols_reg;
    dim_t rows_eff;
    dim_t cols_eff;

    // position counters
    pos_t row_reg, row_next;
    pos_t col_reg, col_next;

    // line memory: [EB-1:0] row r-2, [2EB-1:EB] row r-1
    logic [2*ELEMENT_BITS-1:0] line_mem [MAX_COLS];
    logic [2*ELEMENT_BITS-1:0] rd_data_reg;
    logic [CIDX_W-1:0]         rd_addr;
    logic [CIDX_W+POS_W-1:0]   rd_addr_ext;

    // stage 1
    logic              s1_valid_reg;
    logic [ELEMENT_BITS-1:0] s1_x_reg;
    logic [CIDX_W-1:0] s1_addr_reg;
    pos_t              s1_row_reg;
    pos_t              s1_col_reg;
    logic              s1_win_reg;
    logic              s1_last_reg;

    logic [CS_W-1:0]   rcs0_reg, rcs1_reg;
    logic [CS_W-1:0]   colsum;
    logic [SUM_W-1:0]  win_sum;

    // stage 2
    logic              s2_valid_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    pos_t              s2_row_reg;
    pos_t              s2_col_reg;
    logic              s2_win_reg;
    logic              s2_last_reg;

    // bests
    logic [SUM_W-1:0]  hi_sum_reg, hi_sum_next;
    pos_t              hi_row_reg, hi_row_next;
    pos_t              hi_col_reg, hi_col_next;
    logic [SUM_W-1:0]  lo_sum_reg, lo_sum_next;
    pos_t              lo_row_reg, lo_row_next;
    pos_t              lo_col_reg, lo_col_next;
    logic              seen_reg;
    logic              take_hi, take_lo;
    logic [SUM_W+OUT_SUM_W-1:0] hi_ext, lo_ext;

    // output register
    logic                 out_valid_reg;
    logic [OUT_SUM_W-1:0] max_sum_reg, min_sum_reg;
    pos_t                 max_row_reg, max_col_reg, min_row_reg, min_col_reg;

    logic hold;
    logic accept;
    logic last_row, last_col;

    assign rows_eff = clamp_dim(num_rows_reg, dim_t'(ROW_LIMIT));
    assign cols_eff = clamp_dim(num_cols_reg, dim_t'(COL_TOP));

    assign hold     = s2_valid_reg && s2_last_reg && out_valid_reg && out_stall;
    assign in_stall = hold;
    assign accept   = in_valid && !hold;

    assign last_row = ({1'b0, row_reg} + dim_t'(1)) >= rows_eff;
    assign last_col = ({1'b0, col_reg} + dim_t'(1)) >= cols_eff;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? pos_t'(0) : pos_t'(row_reg + pos_t'(1));
        end
        else
        begin
            col_next = col_reg + pos_t'(1);
        end
    end

    assign rd_addr_ext = {{CIDX_W{1'b0}}, col_reg};
    assign rd_addr     = rd_addr_ext[CIDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= dim_t'(WIN);
            num_cols_reg <= dim_t'(WIN);
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                CFG_NUM_COLS: num_cols_reg <= cfg_data;
                default:      ;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // line memory: read on acceptance, write back from stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[rd_addr];
        if (s1_valid_reg && !hold)
            line_mem[s1_addr_reg] <= {s1_x_reg, rd_data_reg[2*ELEMENT_BITS-1:ELEMENT_BITS]};
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= element_value;
            s1_addr_reg <= rd_addr;
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_win_reg  <= (row_reg >= pos_t'(WIN - 1)) && (col_reg >= pos_t'(WIN - 1));
            s1_last_reg <= last_row && last_col;
        end
    end

    assign colsum  = CS_W'(rd_data_reg[ELEMENT_BITS-1:0])
                   + CS_W'(rd_data_reg[2*ELEMENT_BITS-1:ELEMENT_BITS])
                   + CS_W'(s1_x_reg);
    assign win_sum = SUM_W'(rcs0_reg) + SUM_W'(rcs1_reg) + SUM_W'(colsum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            rcs0_reg     <= '0;
            rcs1_reg     <= '0;
        end
        else if (cfg_we)
        begin
            rcs0_reg <= '0;
            rcs1_reg <= '0;
        end
        else if (!hold)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    rcs0_reg <= '0;
                    rcs1_reg <= '0;
                end
                else
                begin
                    rcs0_reg <= rcs1_reg;
                    rcs1_reg <= colsum;
                end
            end
        end
    end

    // stage 2 payload
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !hold)
        begin
            s2_sum_reg  <= win_sum;
            s2_row_reg  <= s1_row_reg - pos_t'(WIN - 1);
            s2_col_reg  <= s1_col_reg - pos_t'(WIN - 1);
            s2_win_reg  <= s1_win_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // compare and update; strict compare keeps the earliest window on a tie
    always_comb
    begin
        take_hi = s2_win_reg && (!seen_reg || (s2_sum_reg > hi_sum_reg));
        take_lo = s2_win_reg && (!seen_reg || (s2_sum_reg < lo_sum_reg));
        hi_sum_next = take_hi ? s2_sum_reg : hi_sum_reg;
        hi_row_next = take_hi ? s2_row_reg : hi_row_reg;
        hi_col_next = take_hi ? s2_col_reg : hi_col_reg;
        lo_sum_next = take_lo ? s2_sum_reg : lo_sum_reg;
        lo_row_next = take_lo ? s2_row_reg : lo_row_reg;
        lo_col_next = take_lo ? s2_col_reg : lo_col_reg;
        hi_ext = {{OUT_SUM_W{1'b0}}, hi_sum_next};
        lo_ext = {{OUT_SUM_W{1'b0}}, lo_sum_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_sum_reg    <= '0;
            hi_row_reg    <= '0;
            hi_col_reg    <= '0;
            lo_sum_reg    <= '0;
            lo_row_reg    <= '0;
            lo_col_reg    <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                seen_reg <= 1'b0;
            end
            else if (s2_valid_reg && !hold)
            begin
                hi_sum_reg <= hi_sum_next;
                hi_row_reg <= hi_row_next;
                hi_col_reg <= hi_col_next;
                lo_sum_reg <= lo_sum_next;
                lo_row_reg <= lo_row_next;
                lo_col_reg <= lo_col_next;
                seen_reg   <= s2_last_reg ? 1'b0 : (seen_reg || s2_win_reg);
                if (s2_last_reg)
                    out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_last_reg && !hold)
        begin
            max_sum_reg <= hi_ext[OUT_SUM_W-1:0];
            max_row_reg <= hi_row_next;
            max_col_reg <= hi_col_next;
            min_sum_reg <= lo_ext[OUT_SUM_W-1:0];
            min_row_reg <= lo_row_next;
            min_col_reg <= lo_col_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign max_sum   = max_sum_reg;
    assign max_row   = max_row_reg;
    assign max_col   = max_col_reg;
    assign min_sum   = min_sum_reg;
    assign min_row   = min_row_reg;
    assign min_col   = min_col_reg;

endmodule

[design/bx3_checker.sv]
// bx3_checker: port-level checks for box3x3_sum_extrema_search, with its bind.
// Depends on bx3_pkg and the top level's port names.
module bx3_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [bx3_pkg::OUT_SUM_W-1:0]  max_sum,
    input logic [bx3_pkg::POS_W-1:0]      max_row,
    input logic [bx3_pkg::POS_W-1:0]      max_col,
    input logic [bx3_pkg::OUT_SUM_W-1:0]  min_sum,
    input logic [bx3_pkg::POS_W-1:0]      min_row,
    input logic [bx3_pkg::POS_W-1:0]      min_col
);
    import bx3_pkg::*;

    localparam pos_t CORNER_MAX = pos_t'(ROW_LIMIT - WIN);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(max_sum) && $stable(min_sum))
        else $error("stalled result transaction changed or dropped");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_sum <= max_sum)
        else $error("minimum window sum above maximum");

    a_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> max_row <= CORNER_MAX && max_col <= CORNER_MAX
                   && min_row <= CORNER_MAX && min_col <= CORNER_MAX)
        else $error("window corner out of range");

    a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

endmodule

bind box3x3_sum_extrema_search bx3_checker u_bx3_checker (.*);

[sim/testbench.sv]
// testbench: self-checking bench for box3x3_sum_extrema_search. Streams matrices
// through the element channel, predicts the max/min 3x3 window sums and corners,
// and checks every result transaction. Depends on bx3_pkg and the block's RTL.
module testbench;
    import bx3_pkg::*;

    localparam int ELEM_W          = 8;
    localparam int MAX_DIM         = 32;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int RANDOM_ITEMS    = 400;
    localparam int RANDOM_MATRICES = 15;

    typedef logic [OUT_SUM_W-1:0] sum_t;
    typedef logic [ELEM_W-1:0]    elem_t;
    typedef logic [9:0]           colsum_t;

    typedef struct packed {
        sum_t max_sum;
        pos_t max_row;
        pos_t max_col;
        sum_t min_sum;
        pos_t min_row;
        pos_t min_col;
    } extrema_t;

    typedef enum int {
        FILL_ZERO,
        FILL_FULL,
        FILL_LEVEL,
        FILL_RISING,
        FILL_FALLING,
        FILL_UNIFORM,
        FILL_EXTREMES,
        FILL_NARROW,
        FILL_SPARSE
    } fill_t;

    logic      clk           = 1'b0;
    logic      rst_n         = 1'b0;
    logic      cfg_we        = 1'b0;
    cfg_reg_t  cfg_index     = CFG_NUM_ROWS;
    dim_t      cfg_data      = '0;
    logic      in_valid      = 1'b0;
    logic      in_stall;
    elem_t     element_value = '0;
    logic      out_valid;
    logic      out_stall     = 1'b0;
    sum_t      max_sum;
    pos_t      max_row;
    pos_t      max_col;
    sum_t      min_sum;
    pos_t      min_row;
    pos_t      min_col;

    // window search predictor state
    dim_t        rows_setting = dim_t'(3);
    dim_t        cols_setting = dim_t'(3);
    int unsigned next_row     = 0;
    int unsigned next_col     = 0;
    elem_t       two_up [MAX_DIM] = '{default: '0};
    elem_t       one_up [MAX_DIM] = '{default: '0};
    colsum_t     older_colsum = '0;
    colsum_t     newer_colsum = '0;
    extrema_t    best_so_far  = '0;
    bit          window_found = 1'b0;
    extrema_t    expected_extrema [$];
    extrema_t    oldest_result;

    int unsigned mismatches     = 0;
    int unsigned items_accepted = 0;
    int unsigned matrices_done  = 0;

    // idling controls
    bit          sender_gaps   = 1'b0;
    bit          stall_random  = 1'b0;
    int unsigned receiver_hold = 0;
    int unsigned stall_run     = 0;
    logic        stall_level   = 1'b0;

    box3x3_sum_extrema_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .max_sum       (max_sum),
        .max_row       (max_row),
        .max_col       (max_col),
        .min_sum       (min_sum),
        .min_row       (min_row),
        .min_col       (min_col)
    );

    always #5 clk = ~clk;

    function automatic int unsigned effective_dim(dim_t setting);
        if (setting < WIN)
            return WIN;
        if (setting > ROW_LIMIT)
            return ROW_LIMIT;
        return setting;
    endfunction

    task automatic restart_matrix();
        next_row     = 0;
        next_col     = 0;
        older_colsum = '0;
        newer_colsum = '0;
        window_found = 1'b0;
    endtask

    task automatic predict_window_extrema(elem_t value);
        int unsigned rows;
        int unsigned cols;
        colsum_t     column;
        sum_t        window;
        rows   = effective_dim(rows_setting);
        cols   = effective_dim(cols_setting);
        column = colsum_t'(two_up[next_col]) + colsum_t'(one_up[next_col]) + colsum_t'(value);
        two_up[next_col] = one_up[next_col];
        one_up[next_col] = value;
        if (next_row >= WIN - 1 && next_col >= WIN - 1)
        begin
            window = sum_t'(older_colsum) + sum_t'(newer_colsum) + sum_t'(column);
            // strict compare: a tie keeps the earlier window
            if (!window_found || window > best_so_far.max_sum)
            begin
                best_so_far.max_sum = window;
                best_so_far.max_row = pos_t'(next_row - (WIN - 1));
                best_so_far.max_col = pos_t'(next_col - (WIN - 1));
            end
            if (!window_found || window < best_so_far.min_sum)
            begin
                best_so_far.min_sum = window;
                best_so_far.min_row = pos_t'(next_row - (WIN - 1));
                best_so_far.min_col = pos_t'(next_col - (WIN - 1));
            end
            window_found = 1'b1;
        end
        older_colsum = newer_colsum;
        newer_colsum = column;
        if (next_row + 1 >= rows && next_col + 1 >= cols)
        begin
            expected_extrema.push_back(best_so_far);
            matrices_done++;
            restart_matrix();
        end
        else if (next_col + 1 >= cols)
        begin
            next_col = 0;
            next_row++;
        end
        else
        begin
            next_col++;
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic dim_t pick_dimension();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return dim_t'($urandom_range(3, 5));
        if (roll < 95)
            return dim_t'($urandom_range(6, 12));
        if (roll < 98)
            return dim_t'($urandom_range(13, 32));
        return dim_t'($urandom_range(0, 2));
    endfunction

    function automatic elem_t fill_value(fill_t style, int unsigned index);
        case (style)
            FILL_ZERO:     return '0;
            FILL_FULL:     return '1;
            FILL_LEVEL:    return elem_t'(7);
            FILL_RISING:   return elem_t'(index);
            FILL_FALLING:  return elem_t'(255 - index);
            FILL_EXTREMES: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            FILL_NARROW:   return elem_t'($urandom_range(100, 102));
            FILL_SPARSE:   return ($urandom_range(0, 15) == 0) ?
                                  elem_t'($urandom_range(1, 255)) : '0;
            default:       return elem_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_element(elem_t value);
        int unsigned gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_window_extrema(value);
        items_accepted++;
    endtask

    task automatic send_matrix(fill_t style);
        int unsigned count;
        count = effective_dim(rows_setting) * effective_dim(cols_setting);
        for (int unsigned i = 0; i < count; i++)
            send_element(fill_value(style, i));
    endtask

    task automatic send_partial_matrix();
        int unsigned count;
        count = effective_dim(rows_setting) * effective_dim(cols_setting);
        repeat ($urandom_range(1, count - 1))
            send_element(fill_value(FILL_UNIFORM, 0));
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (expected_extrema.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only while idle; either write restarts the matrix
    task automatic set_dimensions(dim_t rows, dim_t cols);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        rows_setting = rows;
        restart_matrix();
        cfg_index <= CFG_NUM_COLS;
        cfg_data  <= cols;
        @(posedge clk);
        cols_setting = cols;
        restart_matrix();
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(string field, sum_t want, sum_t got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_extrema.size() == 0)
            begin
                mismatches++;
                $error("result transaction with none expected: max_sum %0d, min_sum %0d",
                       max_sum, min_sum);
            end
            else
            begin
                oldest_result = expected_extrema.pop_front();
                check_field("max_sum", oldest_result.max_sum, max_sum);
                check_field("max_row", sum_t'(oldest_result.max_row), sum_t'(max_row));
                check_field("max_col", sum_t'(oldest_result.max_col), sum_t'(max_col));
                check_field("min_sum", oldest_result.min_sum, min_sum);
                check_field("min_row", sum_t'(oldest_result.min_row), sum_t'(min_row));
                check_field("min_col", sum_t'(oldest_result.min_col), sum_t'(min_col));
            end
        end
    end

    // result-side back-pressure
    always @(posedge clk)
    begin
        if (receiver_hold != 0)
        begin
            out_stall <= 1'b1;
            receiver_hold--;
        end
        else if (!stall_random)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                case ($urandom_range(0, 99)) inside
                    [0:59]:  begin stall_level = 1'b0; stall_run = $urandom_range(1, 6); end
                    [60:92]: begin stall_level = 1'b1; stall_run = $urandom_range(1, 3); end
                    default: begin stall_level = 1'b1; stall_run = $urandom_range(10, 40); end
                endcase
            end
            stall_run--;
            out_stall <= stall_level;
        end
    end

    task automatic test_value_extremes();
        sender_gaps  = 1'b0;
        stall_random = 1'b0;
        send_matrix(FILL_FULL);
        send_matrix(FILL_ZERO);
        wait_until_idle();
    endtask

    task automatic test_tie_order();
        set_dimensions(dim_t'(3), dim_t'(4));
        send_matrix(FILL_LEVEL);
        send_matrix(FILL_RISING);
        send_matrix(FILL_FALLING);
        wait_until_idle();
    endtask

    task automatic test_register_restart();
        sender_gaps  = 1'b1;
        stall_random = 1'b1;
        repeat (5) send_element(fill_value(FILL_UNIFORM, 0));
        wait_until_idle();
        set_dimensions(dim_t'(4), dim_t'(3));
        send_matrix(FILL_UNIFORM);
        // two full rows and part of the third, then abandoned
        repeat (8) send_element(fill_value(FILL_UNIFORM, 0));
        wait_until_idle();
        set_dimensions(dim_t'(3), dim_t'(3));
        send_matrix(FILL_UNIFORM);
        wait_until_idle();
    endtask

    task automatic test_dimension_limits();
        dim_t row_values [4];
        dim_t col_values [4];
        row_values = '{dim_t'(0), dim_t'(2), dim_t'(63), dim_t'(32)};
        col_values = '{dim_t'(1), dim_t'(63), dim_t'(2), dim_t'(5)};
        sender_gaps  = 1'b1;
        stall_random = 1'b1;
        foreach (row_values[i])
        begin
            set_dimensions(row_values[i], col_values[i]);
            send_matrix(FILL_UNIFORM);
            wait_until_idle();
        end
    endtask

    task automatic test_output_backpressure();
        set_dimensions(dim_t'(3), dim_t'(3));
        sender_gaps   = 1'b0;
        stall_random  = 1'b0;
        receiver_hold = 300;
        repeat (12) send_matrix(FILL_UNIFORM);
        wait_until_idle();
        sender_gaps  = 1'b1;
        stall_random = 1'b1;
        repeat (6) send_matrix(FILL_SPARSE);
        wait_until_idle();
    endtask

    task automatic test_random_matrices();
        int unsigned item_goal;
        int unsigned matrix_goal;
        fill_t       style;
        item_goal   = items_accepted + RANDOM_ITEMS;
        matrix_goal = matrices_done + RANDOM_MATRICES;
        while (items_accepted < item_goal || matrices_done < matrix_goal)
        begin
            set_dimensions(pick_dimension(), pick_dimension());
            sender_gaps  = ($urandom_range(0, 3) != 0);
            stall_random = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 1) != 0)
                    style = FILL_UNIFORM;
                else
                    style = fill_t'($urandom_range(FILL_UNIFORM, FILL_SPARSE));
                send_matrix(style);
            end
            if ($urandom_range(0, 7) == 0)
                send_partial_matrix();
            wait_until_idle();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_value_extremes();
        test_tie_order();
        test_register_restart();
        test_dimension_limits();
        test_output_backpressure();
        test_random_matrices();
        in_valid <= 1'b0;
        for (int unsigned n = 0; n < DRAIN_LIMIT && expected_extrema.size() != 0; n++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_extrema.size() != 0)
            $error("%0d result transactions never arrived", expected_extrema.size());
        if (mismatches == 0 && expected_extrema.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
